// ===== rtl/battery_test_slot_sequencer_defines.svh =====
// Assertion macros shared by the battery test slot sequencer RTL.
`ifndef BATTERY_TEST_SLOT_SEQUENCER_DEFINES_SVH
`define BATTERY_TEST_SLOT_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define BTSS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("btss assertion failed");

// Check a property on every clock edge, reset included.
`define BTSS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("btss assertion failed");

`else

`define BTSS_ASSERT(label, clk, rst_n, prop)
`define BTSS_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== rtl/btss_pkg.sv =====
// Types, codes and constants of the battery test slot sequencer.
`timescale 1ns / 1ps

package btss_pkg;

    // Slot table geometry
    localparam int NUM_SLOTS = 5;
    localparam int SLOT_AW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [4:0] SLOT_LIMIT = 5'(NUM_SLOTS);
    localparam logic [3:0] SLOT_MASK  = 4'hF;

    typedef logic [2:0] stage_t;
    typedef logic [2:0] verdict_t;

    // Stages
    localparam stage_t ST_STANDBY     = 3'd0;
    localparam stage_t ST_CONN        = 3'd1;
    localparam stage_t ST_DISC        = 3'd2;
    localparam stage_t ST_CHECK       = 3'd3;
    localparam stage_t ST_CHARGING    = 3'd4;
    localparam stage_t ST_DISCHARGING = 3'd5;
    localparam stage_t ST_RESULT      = 3'd6;
    localparam stage_t ST_FINAL       = 3'd7;

    // Verdicts
    localparam verdict_t V_NONE     = 3'd0;
    localparam verdict_t V_APPROVED = 3'd1;
    localparam verdict_t V_REPROVED = 3'd2;
    localparam verdict_t V_ABORTED  = 3'd3;
    localparam verdict_t V_HOT      = 3'd4;
    localparam verdict_t V_FINAL    = 3'd5;

    // Event codes
    localparam logic [3:0] EV_OP       = 4'd0;
    localparam logic [3:0] EV_RES_BTN  = 4'd1;
    localparam logic [3:0] EV_CHECK    = 4'd2;
    localparam logic [3:0] EV_NEED_CHG = 4'd3;
    localparam logic [3:0] EV_FULL     = 4'd4;
    localparam logic [3:0] EV_TMR_END  = 4'd5;
    localparam logic [3:0] EV_RES_OK   = 4'd6;
    localparam logic [3:0] EV_NEED_DIS = 4'd7;
    localparam logic [3:0] EV_HOT      = 4'd8;
    localparam logic [3:0] EV_CONN     = 4'd9;
    localparam logic [3:0] EV_DISC     = 4'd10;
    localparam logic [3:0] EV_VOLT     = 4'd11;

    // Mode LED commands
    localparam logic [2:0] MLED_NONE    = 3'd0;
    localparam logic [2:0] MLED_ALL_OFF = 3'd1;
    localparam logic [2:0] MLED_RED     = 3'd2;

    // Result LED commands
    localparam logic [2:0] LED_NONE    = 3'd0;
    localparam logic [2:0] LED_OFF     = 3'd1;
    localparam logic [2:0] LED_ON      = 3'd2;
    localparam logic [2:0] LED_BLINK   = 3'd3;
    localparam logic [2:0] LED_STOP    = 3'd4;
    localparam logic [2:0] LED_STOP_ON = 3'd5;

    // Timer commands
    localparam logic [1:0] TMR_NONE  = 2'd0;
    localparam logic [1:0] TMR_CHECK = 2'd1;
    localparam logic [1:0] TMR_DIS   = 2'd2;

    // Battery commands
    localparam logic [1:0] BAT_NONE   = 2'd0;
    localparam logic [1:0] BAT_CHARGE = 2'd1;
    localparam logic [1:0] BAT_DIS    = 2'd2;
    localparam logic [1:0] BAT_END    = 2'd3;

    // End reasons
    localparam logic [2:0] RSN_NONE     = 3'd0;
    localparam logic [2:0] RSN_DISC     = 3'd1;
    localparam logic [2:0] RSN_HOT      = 3'd2;
    localparam logic [2:0] RSN_REPROVED = 3'd3;
    localparam logic [2:0] RSN_APPROVED = 3'd4;

    // One slot table entry
    typedef struct packed {
        stage_t   stage;
        verdict_t verdict;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // One-shot commands of a decision
    typedef struct packed {
        logic [2:0] mode_led;
        logic [2:0] red;
        logic [2:0] green;
        logic [1:0] timer;
        logic [1:0] battery;
        logic [2:0] reason;
        logic       post;
    } cmd_t;

endpackage

// ===== rtl/btss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module btss_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 5
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/btss_decide.sv =====
// Per-slot stage machine: one decision from an event and the slot's entry.
`timescale 1ns / 1ps

module btss_decide (
    input  logic [3:0]      ev,
    input  logic [7:0]      info,
    input  logic            allow,
    input  btss_pkg::entry_t cur,
    output btss_pkg::entry_t nxt,
    output btss_pkg::cmd_t   cmd
);
    import btss_pkg::*;

    typedef struct packed {
        logic [2:0] red;
        logic [2:0] green;
    } led_pair_t;

    // Result LED pattern that displays a verdict
    function automatic led_pair_t show_verdict(input verdict_t v);
        led_pair_t p;
        p.red   = LED_OFF;
        p.green = LED_OFF;
        case (v)
            V_REPROVED: p.red = LED_ON;
            V_APPROVED: p.green = LED_ON;
            V_FINAL:    p.green = LED_BLINK;
            V_HOT:
            begin
                p.red   = LED_BLINK;
                p.green = LED_BLINK;
            end
            default: ;
        endcase
        return p;
    endfunction

    led_pair_t shown;

    // Step the slot's stage on the event and issue its commands; a test end sets a verdict
    always_comb
    begin
        nxt   = cur;
        cmd   = '0;
        shown = '0;
        unique case (cur.stage) inside
            ST_STANDBY:
            begin
                if (ev == EV_OP && allow)
                begin
                    cmd.mode_led = (info <= 8'd2) ? (info[2:0] + MLED_RED) : MLED_ALL_OFF;
                end
                else if (ev == EV_CONN)
                begin
                    cmd.red   = LED_OFF;
                    cmd.green = LED_OFF;
                    cmd.timer = TMR_CHECK;
                    nxt.stage = ST_CONN;
                end
                else if (ev == EV_DISC)
                begin
                    cmd.red   = LED_OFF;
                    cmd.green = LED_OFF;
                    nxt.stage = ST_DISC;
                end
            end
            ST_CONN:
            begin
                if (ev == EV_CHECK)
                begin
                    nxt.stage = ST_CHECK;
                end
            end
            ST_DISC:
            begin
                if (ev == EV_DISC)
                begin
                    nxt.stage = ST_STANDBY;
                end
            end
            ST_CHECK:
            begin
                if (ev == EV_NEED_CHG)
                begin
                    nxt.stage   = ST_CHARGING;
                    cmd.battery = BAT_CHARGE;
                end
                else if (ev == EV_NEED_DIS)
                begin
                    nxt.stage   = ST_DISCHARGING;
                    cmd.timer   = TMR_DIS;
                    cmd.battery = BAT_DIS;
                end
            end
            ST_CHARGING, ST_DISCHARGING:
            begin
                if (ev == EV_DISC)
                begin
                    cmd.battery = BAT_END;
                    cmd.reason  = RSN_DISC;
                    nxt.verdict = V_ABORTED;
                    nxt.stage   = ST_STANDBY;
                end
                else if (ev == EV_HOT)
                begin
                    cmd.battery = BAT_END;
                    cmd.reason  = RSN_HOT;
                    nxt.verdict = V_HOT;
                    nxt.stage   = ST_RESULT;
                end
                else if (cur.stage == ST_CHARGING)
                begin
                    if (ev == EV_FULL)
                    begin
                        cmd.timer   = TMR_DIS;
                        cmd.battery = BAT_DIS;
                        nxt.stage   = ST_DISCHARGING;
                    end
                end
                else if (ev == EV_VOLT)
                begin
                    cmd.battery = BAT_END;
                    cmd.reason  = RSN_REPROVED;
                    nxt.verdict = V_REPROVED;
                    nxt.stage   = ST_RESULT;
                end
                else if (ev == EV_TMR_END)
                begin
                    cmd.post    = 1'b1;
                    cmd.battery = BAT_END;
                    cmd.reason  = RSN_APPROVED;
                    nxt.verdict = V_APPROVED;
                    nxt.stage   = ST_RESULT;
                end
                // Any test end shows the new verdict
                if (cmd.battery == BAT_END)
                begin
                    shown     = show_verdict(nxt.verdict);
                    cmd.red   = shown.red;
                    cmd.green = shown.green;
                end
            end
            ST_RESULT:
            begin
                if (ev == EV_RES_BTN)
                begin
                    nxt.verdict = V_NONE;
                    nxt.stage   = ST_STANDBY;
                    cmd.red     = LED_OFF;
                    cmd.green   = LED_OFF;
                end
                else if (ev == EV_DISC)
                begin
                    nxt.verdict = V_NONE;
                    nxt.stage   = ST_STANDBY;
                    cmd.red     = LED_STOP;
                    cmd.green   = LED_STOP;
                end
                else if (ev == EV_RES_OK)
                begin
                    cmd.battery = BAT_CHARGE;
                    nxt.verdict = V_FINAL;
                    nxt.stage   = ST_FINAL;
                    shown       = show_verdict(V_FINAL);
                    cmd.red     = shown.red;
                    cmd.green   = shown.green;
                end
            end
            ST_FINAL:
            begin
                if (ev == EV_DISC)
                begin
                    cmd.battery = BAT_END;
                    cmd.reason  = RSN_DISC;
                    nxt.verdict = V_ABORTED;
                    nxt.stage   = ST_STANDBY;
                    shown       = show_verdict(V_ABORTED);
                    cmd.red     = shown.red;
                    cmd.green   = shown.green;
                end
                else if (ev == EV_FULL)
                begin
                    cmd.battery = BAT_END;
                    cmd.reason  = RSN_APPROVED;
                    nxt.verdict = V_APPROVED;
                    cmd.red     = LED_OFF;
                    cmd.green   = LED_STOP_ON;
                end
                else if (ev == EV_RES_BTN)
                begin
                    nxt.verdict = V_NONE;
                    nxt.stage   = ST_STANDBY;
                    cmd.red     = LED_OFF;
                    cmd.green   = LED_OFF;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/battery_test_slot_sequencer.sv =====
// Top level of the battery test slot sequencer: slot table, pipeline and result register.
`timescale 1ns / 1ps
//
// Usage
//   Input channel (in_valid / in_ready): one event per transfer, made of the
//   event code mode, the info word (low four bits select the slot) and the
//   mode_change_allowed flag.
//   Output channel (out_valid / out_ready): one result per event, in order:
//   accepted, slot, the slot's new stage and verdict, and the one-shot LED,
//   timer, battery, end reason and result-ok commands.
//   Throughput: one event per cycle while out_ready is high. The slot table
//   sits in a RAM with registered read data; an event reads its entry when
//   taken, decides and writes back as it leaves the decision stage; a bypass
//   register serves an event that follows right behind one for the same slot.
//   Result path: a taken event sits in the decision stage register and moves
//   on into the result register, which drives the outputs, once that is free.
//   Reset: all slots start in standby with no verdict (per-entry valid bits,
//   no clearing pass); pipeline and output are emptied.
//   Stall: while out_ready is low the result holds; one more event waits in
//   the decision stage, after which in_ready drops until the output drains.
//
`include "battery_test_slot_sequencer_defines.svh"

module battery_test_slot_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [3:0]           mode,
    input  logic [7:0]           info,
    input  logic                 mode_change_allowed,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 accepted,
    output logic [3:0]           slot,
    output btss_pkg::stage_t     new_stage,
    output btss_pkg::verdict_t   verdict,
    output logic [2:0]           mode_led_cmd,
    output logic [2:0]           red_led_cmd,
    output logic [2:0]           green_led_cmd,
    output logic [1:0]           timer_cmd,
    output logic [1:0]           battery_cmd,
    output logic [2:0]           end_reason,
    output logic                 post_result_ok
);
    import btss_pkg::*;

    // Handshake and pipeline control
    logic                 in_fire;
    logic                 s1_adv;
    logic                 s1_valid_reg, s1_valid_next;
    logic                 out_valid_reg, out_valid_next;

    // Decision stage payload
    logic [3:0]           s1_mode_reg;
    logic [7:0]           s1_info_reg;
    logic                 s1_allow_reg;

    logic [3:0]           in_slot;
    logic [SLOT_AW-1:0]   in_idx;
    logic [3:0]           s1_slot;
    logic [SLOT_AW-1:0]   s1_idx;
    logic                 s1_slot_ok;
    logic                 s1_acc;

    // Slot table access
    logic                 wr_en;
    entry_t               ram_rdata;
    entry_t               cur_entry;
    entry_t               nxt_entry;
    cmd_t                 dec_cmd;
    logic [NUM_SLOTS-1:0] entry_valid_reg;
    logic                 fwd_valid_reg;
    logic [SLOT_AW-1:0]   fwd_idx_reg;
    entry_t               fwd_data_reg;

    // Result register
    logic                 acc_reg;
    logic [3:0]           slot_reg;
    entry_t               res_entry_reg;
    cmd_t                 res_cmd_reg;

    // Take a new event whenever the decision stage is free or moving on
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign in_slot = info[3:0] & SLOT_MASK;
    assign in_idx  = in_slot[SLOT_AW-1:0];

    assign s1_slot    = s1_info_reg[3:0] & SLOT_MASK;
    assign s1_idx     = s1_slot[SLOT_AW-1:0];
    assign s1_slot_ok = {1'b0, s1_slot} < SLOT_LIMIT;
    assign s1_acc     = s1_slot_ok && (s1_mode_reg <= EV_VOLT);
    assign wr_en      = s1_adv && s1_acc;

    btss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_idx),
        .wdata (nxt_entry),
        .re    (in_fire),
        .raddr (in_idx),
        .rdata (ram_rdata)
    );

    // Pick the slot entry: bypass, then table, then reset value
    always_comb
    begin
        if (fwd_valid_reg && fwd_idx_reg == s1_idx)
        begin
            cur_entry = fwd_data_reg;
        end
        else if (s1_slot_ok && entry_valid_reg[s1_idx])
        begin
            cur_entry = ram_rdata;
        end
        else
        begin
            cur_entry = '0;
        end
    end

    btss_decide u_decide (
        .ev    (s1_mode_reg),
        .info  (s1_info_reg),
        .allow (s1_allow_reg),
        .cur   (cur_entry),
        .nxt   (nxt_entry),
        .cmd   (dec_cmd)
    );

    // Next control state
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers, valid bits and bypass tag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            entry_valid_reg <= '0;
            fwd_valid_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                entry_valid_reg[s1_idx] <= 1'b1;
                fwd_valid_reg           <= 1'b1;
            end
        end
    end

    // Capture the event and the last table write
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_mode_reg  <= mode;
            s1_info_reg  <= info;
            s1_allow_reg <= mode_change_allowed;
        end
        if (wr_en)
        begin
            fwd_idx_reg  <= s1_idx;
            fwd_data_reg <= nxt_entry;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            acc_reg       <= s1_acc;
            slot_reg      <= s1_slot;
            res_entry_reg <= s1_acc ? nxt_entry : '0;
            res_cmd_reg   <= s1_acc ? dec_cmd : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign accepted       = acc_reg;
    assign slot           = slot_reg;
    assign new_stage      = res_entry_reg.stage;
    assign verdict        = res_entry_reg.verdict;
    assign mode_led_cmd   = res_cmd_reg.mode_led;
    assign red_led_cmd    = res_cmd_reg.red;
    assign green_led_cmd  = res_cmd_reg.green;
    assign timer_cmd      = res_cmd_reg.timer;
    assign battery_cmd    = res_cmd_reg.battery;
    assign end_reason     = res_cmd_reg.reason;
    assign post_result_ok = res_cmd_reg.post;

    // Checks
    `BTSS_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |-> !out_valid_reg && !s1_valid_reg)
    `BTSS_ASSERT(a_acc_slot, clk, rst_n, out_valid_reg && acc_reg |-> {1'b0, slot_reg} < SLOT_LIMIT)
    `BTSS_ASSERT(a_rej_quiet, clk, rst_n, out_valid_reg && !acc_reg |-> res_entry_reg == '0 && res_cmd_reg == '0)
    `BTSS_ASSERT(a_reason_end, clk, rst_n, out_valid_reg && end_reason != RSN_NONE |-> battery_cmd == BAT_END)
    `BTSS_ASSERT(a_write_hit, clk, rst_n, $past(wr_en) |-> entry_valid_reg[fwd_idx_reg] && fwd_valid_reg)

endmodule
